>>> design/layer_pixel_blend_hsv_core_assert.svh
// Assertion macros shared by the blend core.
// Both macros take a label, a clock, a reset, an antecedent and a consequent.
`ifndef LAYER_PIXEL_BLEND_HSV_CORE_ASSERT_SVH
`define LAYER_PIXEL_BLEND_HSV_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPBH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpbh assertion failed");

// Next-cycle implication.
`define LPBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpbh assertion failed");

`endif

>>> design/lpbh_pkg.sv
`default_nettype none

package lpbh_pkg;

   // Channel and curve table geometry.
   localparam int ChanMax    = 255;
   localparam int ChanSq     = 255 * 255;
   localparam int HueSteps   = 1530;
   localparam int HueMult    = HueSteps / ChanMax;
   localparam int CurveDepth = 256;
   localparam int NumLanes   = 4;

   // Reciprocal of 255 scaled by 2**32, exact for 24-bit dividends.
   localparam logic [24:0] RecipDiv255 = 25'd16843010;

   // Configuration port geometry and register indexes.
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 4;
   localparam logic [CsrIdxW-1:0] RegChannelMask    = 3'd0;
   localparam logic [CsrIdxW-1:0] RegAlphaBlendMode = 3'd1;
   localparam logic [CsrIdxW-1:0] RegMultiplyMode   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegHsvConvert     = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSourcePresent  = 3'd4;
   localparam logic [CsrIdxW-1:0] RegSourceGrey     = 3'd5;

   // Request opcodes.
   localparam logic OpWrite = 1'b0;
   localparam logic OpBlend = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] curve_index;
      logic [7:0] curve_value;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic [7:0] src_c0;
      logic [7:0] src_c1;
      logic [7:0] src_c2;
      logic [7:0] src_c3;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic [3:0] channel_mask;
      logic       alpha_blend_mode;
      logic       multiply_mode;
      logic       hsv_convert;
      logic       source_present;
      logic       source_grey;
   } cfg_type;

   // Load enables of the pipeline stages, front to back.
   typedef struct packed {
      logic rd;
      logic blend;
      logic hsv_a;
      logic hsv_b;
      logic hsv_c;
      logic out;
   } stage_en_type;

   // Exact floor(x / 255) for x up to 255 * 255.
   function automatic logic [7:0] div255_narrow(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   // Exact floor(y / 255) for y < 255 * 65536, via the reciprocal.
   function automatic logic [15:0] div255_wide(input logic [23:0] y);
      logic [48:0] prod;
      prod = 49'(y) * 49'(RecipDiv255);
      return prod[47:32];
   endfunction

endpackage

`default_nettype wire

>>> design/lpbh_if.sv
`default_nettype none

// Request channel: one curve write or one pixel blend per transfer.
interface lpbh_req_if;
   logic              valid;
   logic              ready;
   lpbh_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Response channel: one blended pixel per transfer.
interface lpbh_rsp_if;
   logic              valid;
   logic              ready;
   lpbh_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/lpbh_ram.sv
`default_nettype none

module lpbh_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/lpbh_lane.sv
`default_nettype none

module lpbh_lane (
   input  wire logic                   clock,
   input  wire lpbh_pkg::stage_en_type en,
   input  wire lpbh_pkg::cfg_type      cfg,
   input  wire logic                   lane_on,
   input  wire logic                   wr_en,
   input  wire logic [7:0]             wr_addr,
   input  wire logic [7:0]             wr_data,
   input  wire logic [7:0]             dst,
   input  wire logic [7:0]             src,
   input  wire logic [7:0]             alpha,
   output logic      [7:0]             chan
);

   logic [7:0]  rd_addr;
   logic [7:0]  curve;
   logic [7:0]  dst_ff;
   logic [7:0]  n;
   logic [7:0]  d;
   logic [8:0]  scale;
   logic [16:0] prod_a;
   logic [15:0] prod_b;
   logic [16:0] mix;
   logic [8:0]  add_sum;
   logic [7:0]  blend;
   logic [7:0]  chan_in;
   logic [7:0]  chan_ff;

   // With a source the source component is mapped, otherwise the destination.
   assign rd_addr = cfg.source_present ? src : dst;

   // Private copy of the curve table for this channel.
   lpbh_ram #(
      .Width (8),
      .Depth (lpbh_pkg::CurveDepth)
   ) u_curve_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (en.rd),
      .rd_addr (rd_addr),
      .rd_data (curve)
   );

   // Destination value travels alongside the table read.
   always_ff @(posedge clock) begin
      if (en.rd) begin
         dst_ff <= dst;
      end
   end

   // Blend: alpha mix, multiply or saturating add; a masked lane passes the destination.
   always_comb begin
      n       = cfg.source_present ? curve : 8'd0;
      d       = cfg.source_present ? dst_ff : curve;
      scale   = cfg.alpha_blend_mode ? {1'b0, ~alpha} : 9'(n) + 9'd1;
      prod_a  = 17'(d) * 17'(scale);
      prod_b  = 16'(alpha) * 16'(n);
      mix     = prod_a + 17'(prod_b);
      add_sum = 9'(d) + 9'(n);
      if (cfg.alpha_blend_mode) begin
         blend = mix[15:8];
      end else if (cfg.multiply_mode) begin
         blend = prod_a[15:8];
      end else begin
         blend = add_sum[8] ? 8'hFF : add_sum[7:0];
      end
      chan_in = lane_on ? blend : dst_ff;
   end

   always_ff @(posedge clock) begin
      if (en.blend) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

>>> design/lpbh_hsv.sv
`default_nettype none

module lpbh_hsv (
   input  wire logic                   clock,
   input  wire lpbh_pkg::stage_en_type en,
   input  wire logic                   hsv_convert,
   input  wire logic [7:0]             hue,
   input  wire logic [7:0]             sat,
   input  wire logic [7:0]             val,
   input  wire logic [7:0]             alpha,
   output lpbh_pkg::rsp_type           result
);

   // Hue sectors of the conversion.
   localparam logic [2:0] SecRedYellow  = 3'd0;
   localparam logic [2:0] SecYellowGrn  = 3'd1;
   localparam logic [2:0] SecGreenCyan  = 3'd2;
   localparam logic [2:0] SecCyanBlue   = 3'd3;
   localparam logic [2:0] SecBlueMag    = 3'd4;

   logic [10:0] h6;
   logic [15:0] sf;
   logic [15:0] sg;

   logic [7:0]  a_h_ff, a_s_ff, a_v_ff, a_alpha_ff, a_ps_ff;
   logic [2:0]  a_sector_ff;
   logic [15:0] a_kq_ff, a_kx_ff;

   logic [7:0]  b_h_ff, b_s_ff, b_v_ff, b_alpha_ff;
   logic [2:0]  b_sector_ff;
   logic [23:0] b_yq_ff, b_yx_ff;
   logic [15:0] b_yp_ff;

   logic [7:0]  c_h_ff, c_s_ff, c_v_ff, c_alpha_ff, c_p_ff;
   logic [2:0]  c_sector_ff;
   logic [15:0] c_tq_ff, c_tx_ff;

   logic [7:0]  q;
   logic [7:0]  x;
   lpbh_pkg::rsp_type out_in;
   lpbh_pkg::rsp_type out_ff;

   // Sector, fraction and the saturation products.
   always_comb begin
      h6 = 11'(hue) * 11'(lpbh_pkg::HueMult);
      sf = 16'(sat) * 16'(h6[7:0]);
      sg = 16'(sat) * {8'd0, ~h6[7:0]};
   end

   always_ff @(posedge clock) begin
      if (en.hsv_a) begin
         a_h_ff      <= hue;
         a_s_ff      <= sat;
         a_v_ff      <= val;
         a_alpha_ff  <= alpha;
         a_ps_ff     <= ~sat;
         a_sector_ff <= h6[10:8];
         a_kq_ff     <= 16'(lpbh_pkg::ChanSq) - sf;
         a_kx_ff     <= 16'(lpbh_pkg::ChanSq) - sg;
      end
   end

   // Scale the three weights by the value.
   always_ff @(posedge clock) begin
      if (en.hsv_b) begin
         b_h_ff      <= a_h_ff;
         b_s_ff      <= a_s_ff;
         b_v_ff      <= a_v_ff;
         b_alpha_ff  <= a_alpha_ff;
         b_sector_ff <= a_sector_ff;
         b_yq_ff     <= 24'(a_v_ff) * 24'(a_kq_ff);
         b_yx_ff     <= 24'(a_v_ff) * 24'(a_kx_ff);
         b_yp_ff     <= 16'(a_v_ff) * 16'(a_ps_ff);
      end
   end

   // First division by 255; p is finished here.
   always_ff @(posedge clock) begin
      if (en.hsv_c) begin
         c_h_ff      <= b_h_ff;
         c_s_ff      <= b_s_ff;
         c_v_ff      <= b_v_ff;
         c_alpha_ff  <= b_alpha_ff;
         c_sector_ff <= b_sector_ff;
         c_tq_ff     <= lpbh_pkg::div255_wide(b_yq_ff);
         c_tx_ff     <= lpbh_pkg::div255_wide(b_yx_ff);
         c_p_ff      <= lpbh_pkg::div255_narrow(b_yp_ff);
      end
   end

   // Second division by 255; sector picks order if converting, s > 0.
   always_comb begin
      q = lpbh_pkg::div255_narrow(c_tq_ff);
      x = lpbh_pkg::div255_narrow(c_tx_ff);
      out_in.out_alpha = c_alpha_ff;
      if (!hsv_convert) begin
         out_in.out_red   = c_h_ff;
         out_in.out_green = c_s_ff;
         out_in.out_blue  = c_v_ff;
      end else if (c_s_ff == 8'd0) begin
         out_in.out_red   = c_v_ff;
         out_in.out_green = c_v_ff;
         out_in.out_blue  = c_v_ff;
      end else begin
         case (c_sector_ff)
            SecRedYellow: begin
               out_in.out_red   = c_v_ff;
               out_in.out_green = x;
               out_in.out_blue  = c_p_ff;
            end
            SecYellowGrn: begin
               out_in.out_red   = q;
               out_in.out_green = c_v_ff;
               out_in.out_blue  = c_p_ff;
            end
            SecGreenCyan: begin
               out_in.out_red   = c_p_ff;
               out_in.out_green = c_v_ff;
               out_in.out_blue  = x;
            end
            SecCyanBlue: begin
               out_in.out_red   = c_p_ff;
               out_in.out_green = q;
               out_in.out_blue  = c_v_ff;
            end
            SecBlueMag: begin
               out_in.out_red   = x;
               out_in.out_green = c_p_ff;
               out_in.out_blue  = c_v_ff;
            end
            default: begin
               out_in.out_red   = c_v_ff;
               out_in.out_green = c_p_ff;
               out_in.out_blue  = q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en.out) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

`default_nettype wire

>>> design/layer_pixel_blend_hsv_core.sv
// Pixel layer blend with curve table and optional HSV-to-RGB conversion.
// Requests arrive on req_chan (valid/ready). A request with the write opcode
// stores curve_value at curve_index in the curve table and gives no response.
// A request with the blend opcode gives one response on rsp_chan: the blended
// destination pixel, channels 0..2 optionally converted from HSV to RGB.
// Configuration registers are written through csr_wr_en, csr_index and
// csr_wr_data, one register per cycle; the user must write them only while
// the core is idle, since the core does not enforce this. Throughput is one
// request per cycle while the response side does not stall. A blend request
// passes six register stages: one for the curve table read, one for the
// lane blend, four for the conversion pipeline.
// The curve table is held in five identical single-read RAMs, one per channel
// lane plus one for the source alpha, which is what allows one pixel a cycle.
// After reset the core loads the identity curve into all 256 entries of the
// RAMs; req_chan.ready stays low during that time. When the receiver stalls,
// the response is held and the stages behind it keep filling, so requests are
// still taken until every stage holds a pixel.
`default_nettype none

`include "layer_pixel_blend_hsv_core_assert.svh"

module layer_pixel_blend_hsv_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lpbh_req_if.sink                               req_chan,
   lpbh_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [lpbh_pkg::CsrIdxW-1:0]      csr_index,
   input  wire logic [lpbh_pkg::CsrDataW-1:0]     csr_wr_data
);

   localparam int NumStages = 6;

   lpbh_pkg::cfg_type      cfg_in;
   lpbh_pkg::cfg_type      cfg_ff;
   lpbh_pkg::stage_en_type en;
   lpbh_pkg::req_type      req;

   logic [NumStages-1:0] en_vec;
   logic [NumStages-1:0] v_in;
   logic [NumStages-1:0] v_ff;

   logic       clearing_in;
   logic       clearing_ff;
   logic [7:0] clear_idx_in;
   logic [7:0] clear_idx_ff;

   logic       accept;
   logic       wr_acc;
   logic       blend_acc;
   logic       ram_wr_en;
   logic [7:0] ram_wr_addr;
   logic [7:0] ram_wr_data;

   logic [7:0] dst_vec   [lpbh_pkg::NumLanes];
   logic [7:0] src_vec   [lpbh_pkg::NumLanes];
   logic [7:0] chan_vec  [lpbh_pkg::NumLanes];
   logic [7:0] alpha_addr;
   logic [7:0] alpha_q;
   logic [7:0] alpha_s1;

   assign req = req_chan.payload;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lpbh_pkg::RegChannelMask:    cfg_in.channel_mask     = csr_wr_data[3:0];
            lpbh_pkg::RegAlphaBlendMode: cfg_in.alpha_blend_mode = csr_wr_data[0];
            lpbh_pkg::RegMultiplyMode:   cfg_in.multiply_mode    = csr_wr_data[0];
            lpbh_pkg::RegHsvConvert:     cfg_in.hsv_convert      = csr_wr_data[0];
            lpbh_pkg::RegSourcePresent:  cfg_in.source_present   = csr_wr_data[0];
            lpbh_pkg::RegSourceGrey:     cfg_in.source_grey      = csr_wr_data[0];
            default:                     cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Identity load of the curve RAMs after reset.
   assign clear_idx_in = clear_idx_ff + 8'd1;
   assign clearing_in  = clearing_ff && (clear_idx_ff != 8'hFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   // Stage enables: a stage loads when it is empty or its contents move on.
   always_comb begin
      en_vec[NumStages-1] = !v_ff[NumStages-1] || rsp_chan.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         en_vec[k] = !v_ff[k] || en_vec[k+1];
      end
   end

   assign en.rd    = en_vec[0];
   assign en.blend = en_vec[1];
   assign en.hsv_a = en_vec[2];
   assign en.hsv_b = en_vec[3];
   assign en.hsv_c = en_vec[4];
   assign en.out   = en_vec[5];

   // Request handshake.
   assign req_chan.ready = !clearing_ff && en_vec[0];
   assign accept         = req_chan.valid && req_chan.ready;
   assign wr_acc         = accept && (req.opcode == lpbh_pkg::OpWrite);
   assign blend_acc      = accept && (req.opcode == lpbh_pkg::OpBlend);

   // Stage valid bits; curve writes never enter the pipeline.
   always_comb begin
      v_in[0] = en_vec[0] ? blend_acc : v_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         v_in[k] = en_vec[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Shared write port of all curve RAM copies.
   assign ram_wr_en   = clearing_ff || wr_acc;
   assign ram_wr_addr = clearing_ff ? clear_idx_ff : req.curve_index;
   assign ram_wr_data = clearing_ff ? clear_idx_ff : req.curve_value;

   // Channel inputs; a grey source feeds component 0 everywhere.
   assign dst_vec[0] = req.dst_red;
   assign dst_vec[1] = req.dst_green;
   assign dst_vec[2] = req.dst_blue;
   assign dst_vec[3] = req.dst_alpha;
   assign src_vec[0] = req.src_c0;
   assign src_vec[1] = cfg_ff.source_grey ? req.src_c0 : req.src_c1;
   assign src_vec[2] = cfg_ff.source_grey ? req.src_c0 : req.src_c2;
   assign src_vec[3] = cfg_ff.source_grey ? req.src_c0 : req.src_c3;
   assign alpha_addr = src_vec[3];

   // Curve copy for the source alpha.
   lpbh_ram #(
      .Width (8),
      .Depth (lpbh_pkg::CurveDepth)
   ) u_alpha_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (en.rd),
      .rd_addr (alpha_addr),
      .rd_data (alpha_q)
   );

   assign alpha_s1 = cfg_ff.source_present ? alpha_q : 8'd0;

   // One blend lane per channel.
   for (genvar i = 0; i < lpbh_pkg::NumLanes; i++) begin : g_lane
      lpbh_lane u_lane (
         .clock   (clock),
         .en      (en),
         .cfg     (cfg_ff),
         .lane_on (cfg_ff.channel_mask[i]),
         .wr_en   (ram_wr_en),
         .wr_addr (ram_wr_addr),
         .wr_data (ram_wr_data),
         .dst     (dst_vec[i]),
         .src     (src_vec[i]),
         .alpha   (alpha_s1),
         .chan    (chan_vec[i])
      );
   end

   // Merge of the lanes: color conversion and response register.
   lpbh_hsv u_hsv (
      .clock       (clock),
      .en          (en),
      .hsv_convert (cfg_ff.hsv_convert),
      .hue         (chan_vec[0]),
      .sat         (chan_vec[1]),
      .val         (chan_vec[2]),
      .alpha       (chan_vec[3]),
      .result      (rsp_chan.payload)
   );

   assign rsp_chan.valid = v_ff[NumStages-1];

   // The pipeline stays empty while the curve RAMs are being loaded.
   `LPBH_ASSERT_NOW(a_empty_in_clear, clock, reset, clearing_ff, v_ff == 6'd0)
   // The identity load covers every entry before it ends.
   `LPBH_ASSERT_NOW(a_clear_full, clock, reset, $fell(clearing_ff), $past(clear_idx_ff) == 8'hFF)
   // A curve write request leaves no pixel in the first stage.
   `LPBH_ASSERT_NEXT(a_write_no_pixel, clock, reset, wr_acc, !v_ff[0])
   // A blend request always lands in the first stage.
   `LPBH_ASSERT_NEXT(a_blend_enters, clock, reset, blend_acc, v_ff[0])

endmodule

`default_nettype wire
